[sv/tjd_pkg.sv]
// Shared types and constants for the touch jump detector with baseline.
package tjd_pkg;

   // Width of one sensed charge time and of the baseline average.
   localparam int SENSE_BITS = 20;
   localparam int SENS_BITS  = 4;
   localparam int SHIFT_BITS = 4;
   localparam int GAP_BITS   = 16;
   localparam int TIME_BITS  = 32;

   // Largest shift the decay setting can name.
   localparam int MAX_SHIFT  = (1 << SHIFT_BITS) - 1;

   // Room for (average << shift) - average + sample at the largest shift.
   localparam int WIDE_BITS  = SENSE_BITS + MAX_SHIFT + 1;

   // Product of the baseline and the sensitivity.
   localparam int PROD_BITS  = SENSE_BITS + SENS_BITS;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SENSITIVITY = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECAY_SHIFT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_GAP_MS  = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [SENS_BITS-1:0]  SENSITIVITY_RESET = 4'd2;
   localparam logic [SHIFT_BITS-1:0] DECAY_SHIFT_RESET = 4'd2;
   localparam logic [GAP_BITS-1:0]   MIN_GAP_MS_RESET  = 16'd200;

   // Door event codes.
   localparam logic [1:0] DOOR_NONE    = 2'd0;
   localparam logic [1:0] DOOR_EV_OPEN = 2'd1;
   localparam logic [1:0] DOOR_EV_SHUT = 2'd2;

   typedef struct packed {
      logic [SENS_BITS-1:0]  sensitivity;
      logic [SHIFT_BITS-1:0] decay_shift;
      logic [GAP_BITS-1:0]   min_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic                  door_level;
      logic [SENSE_BITS-1:0] sense_time;
      logic [TIME_BITS-1:0]  now_ms;
   } sample_type;

   typedef struct packed {
      logic [1:0]            door_event;
      logic                  touched;
      logic [SENSE_BITS-1:0] baseline;
   } result_type;

endpackage

[sv/touch_jump_detector_with_baseline_core.sv]
// Top level of the touch jump detector with baseline.
//
// The block takes one sample beat per cycle while the output is not
// stalled and returns exactly one result beat per sample, in order. A
// sample is captured in an input register; once the result register is
// free or being emptied, the detector compares it with the baseline
// times the sensitivity, updates the baseline average, the door level
// and the last touch time, and loads the result register, which holds
// the result beat until it is taken. The sustained rate is one sample
// per cycle with rsp_ready high: the state update is a single step of one
// 20x4 multiply, one wide shift-add and one 32-bit wrapping subtract, and
// the next sample sees the updated state as soon as it reaches the detector.
// While a finished result waits for rsp_ready, the input register still
// accepts one more sample. Configuration writes are taken at any time
// through the csr_ port (csr_ready is always high) but must only be issued
// while no sample is in flight; a write to an index beyond the three
// registers is ignored.
module touch_jump_detector_with_baseline_core (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_door_level,
   input  logic [tjd_pkg::SENSE_BITS-1:0]      req_sense_time,
   input  logic [tjd_pkg::TIME_BITS-1:0]       req_now_ms,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_door_event,
   output logic                                rsp_touched,
   output logic [tjd_pkg::SENSE_BITS-1:0]      rsp_baseline,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tjd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tjd_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import tjd_pkg::*;

   cfg_type    cfg;
   sample_type sample_ff;
   sample_type sample_in;
   logic       sample_valid_ff;
   logic       sample_valid_in;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_fire;
   logic       advance;

   assign csr_ready = 1'b1;

   tjd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // The held sample moves on whenever the result register is free or is
   // being emptied in this cycle; the input register refills in the same
   // cycle.
   assign advance   = sample_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !sample_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      sample_in.door_level = req_door_level;
      sample_in.sense_time = req_sense_time;
      sample_in.now_ms     = req_now_ms;

      if (req_fire) begin
         sample_valid_in = 1'b1;
      end else if (advance) begin
         sample_valid_in = 1'b0;
      end else begin
         sample_valid_in = sample_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   tjd_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .sample  (sample_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sample_valid_ff <= sample_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= sample_in;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_door_event = result_ff.door_event;
   assign rsp_touched    = result_ff.touched;
   assign rsp_baseline   = result_ff.baseline;

   // An empty input register always takes a new beat.
   assert property (@(posedge clock) disable iff (reset)
      !sample_valid_ff |-> req_ready)
      else $error("input register empty but not ready");

   // A held sample that cannot move on is kept.
   assert property (@(posedge clock) disable iff (reset)
      sample_valid_ff && !advance |=> sample_valid_ff && $stable(sample_ff))
      else $error("stalled sample lost");

   // A sample that moves on always produces a result beat.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result beat missing after a step");

   // The door event code is never the unused value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_door_event == DOOR_NONE || rsp_door_event == DOOR_EV_OPEN
                        || rsp_door_event == DOOR_EV_SHUT))
      else $error("invalid door event code");

endmodule

[sv/tjd_csr.sv]
// Configuration registers of the touch jump detector.
module tjd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [tjd_pkg::CSR_INDEX_BITS-1:0]  wr_index,
   input  logic [tjd_pkg::CSR_DATA_BITS-1:0]   wr_data,
   output tjd_pkg::cfg_type                    cfg
);
   import tjd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes to an index beyond the register list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_SENSITIVITY: cfg_in.sensitivity = wr_data[SENS_BITS-1:0];
            CSR_DECAY_SHIFT: cfg_in.decay_shift = wr_data[SHIFT_BITS-1:0];
            CSR_MIN_GAP_MS:  cfg_in.min_gap_ms  = wr_data[GAP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensitivity <= SENSITIVITY_RESET;
         cfg_ff.decay_shift <= DECAY_SHIFT_RESET;
         cfg_ff.min_gap_ms  <= MIN_GAP_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/tjd_step.sv]
// Detector state and the single-pass update for one sample.
module tjd_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  tjd_pkg::sample_type sample,
   input  tjd_pkg::cfg_type    cfg,
   output tjd_pkg::result_type result
);
   import tjd_pkg::*;

   logic                  door_was_open_ff;
   logic                  door_was_open_in;
   logic [SENSE_BITS-1:0] average_ff;
   logic [SENSE_BITS-1:0] average_in;
   logic                  primed_ff;
   logic                  primed_in;
   logic [TIME_BITS-1:0]  last_touch_ms_ff;
   logic [TIME_BITS-1:0]  last_touch_ms_in;

   logic [PROD_BITS-1:0]  threshold;
   logic                  jump;
   logic [WIDE_BITS-1:0]  avg_wide;
   logic [WIDE_BITS-1:0]  decay_sum;
   logic [WIDE_BITS-1:0]  decay_shifted;
   logic [TIME_BITS-1:0]  gap;
   logic                  gap_ok;
   logic                  touch;

   always_comb begin
      threshold = PROD_BITS'(average_ff) * PROD_BITS'(cfg.sensitivity);
      jump      = primed_ff && (PROD_BITS'(sample.sense_time) > threshold);

      // Moving average: ((avg << k) - avg + t) >> k, wide enough for k = 15.
      avg_wide      = WIDE_BITS'(average_ff);
      decay_sum     = (avg_wide << cfg.decay_shift) - avg_wide
                      + WIDE_BITS'(sample.sense_time);
      decay_shifted = decay_sum >> cfg.decay_shift;

      // Wrapping distance since the last reported touch.
      gap    = sample.now_ms - last_touch_ms_ff;
      gap_ok = gap > TIME_BITS'(cfg.min_gap_ms);
      touch  = jump && gap_ok;

      door_was_open_in = sample.door_level;
      primed_in        = 1'b1;
      last_touch_ms_in = touch ? sample.now_ms : last_touch_ms_ff;
      if (!primed_ff || jump) begin
         average_in = sample.sense_time;
      end else begin
         average_in = decay_shifted[SENSE_BITS-1:0];
      end

      if (sample.door_level == door_was_open_ff) begin
         result.door_event = DOOR_NONE;
      end else if (sample.door_level) begin
         result.door_event = DOOR_EV_OPEN;
      end else begin
         result.door_event = DOOR_EV_SHUT;
      end
      result.touched  = touch;
      result.baseline = average_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         door_was_open_ff <= 1'b0;
         average_ff       <= '0;
         primed_ff        <= 1'b0;
         last_touch_ms_ff <= '0;
      end else if (step_en) begin
         door_was_open_ff <= door_was_open_in;
         average_ff       <= average_in;
         primed_ff        <= primed_in;
         last_touch_ms_ff <= last_touch_ms_in;
      end
   end

   // The first sample after reset can never report a touch.
   assert property (@(posedge clock) disable iff (reset)
      !primed_ff |-> !touch)
      else $error("touch reported before the baseline was loaded");

   // A reported touch records its timestamp.
   assert property (@(posedge clock) disable iff (reset)
      step_en && touch |=> last_touch_ms_ff == $past(sample.now_ms))
      else $error("last touch time not updated");

   // A jump always replaces the baseline with the sample.
   assert property (@(posedge clock) disable iff (reset)
      step_en && jump |=> average_ff == $past(sample.sense_time))
      else $error("baseline not replaced on a jump");

endmodule
